/* hw/rtl/vrv_pkg.sv */
// Package for the 2:1 voxel restriction block with averaged value and type vote.
// Holds the accumulator entry type, divider request type, codes and fixed widths.
// No dependencies.
package vrv_pkg;

	// Fixed field widths.
	localparam int VALUE_W = 32;
	localparam int SUM_W   = 35;
	localparam int CNT_W   = 4;
	localparam int CFG_W   = 9;
	localparam int IDX_W   = 2;

	// Bit-serial divider: one quotient bit per step over the whole dividend.
	localparam int DIV_STEPS = SUM_W;
	localparam int STEP_W    = $clog2(DIV_STEPS + 1);

	// Voxel type codes.
	localparam logic [1:0] TYPE_AIR    = 2'd0;
	localparam logic [1:0] TYPE_SOLID  = 2'd1;
	localparam logic [1:0] TYPE_ANCHOR = 2'd2;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] CFG_SIZE_X = 2'd0;
	localparam logic [IDX_W-1:0] CFG_SIZE_Y = 2'd1;
	localparam logic [IDX_W-1:0] CFG_SIZE_Z = 2'd2;

	// One accumulator entry: 47 bits.
	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [CNT_W-1:0]        count;
		logic [CNT_W-1:0]        solid;
		logic [CNT_W-1:0]        anchor;
	} acc_entry_t;

	// Request to the divider: magnitude already biased by half the divisor.
	typedef struct packed {
		logic             neg;
		logic [SUM_W-1:0] mag;
		logic [CNT_W-1:0] den;
	} div_req_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RD   = 4'b0010,
		ST_PREP = 4'b0100,
		ST_DIV  = 4'b1000
	} state_t;

endpackage

/* hw/rtl/vrv_acc_mem.sv */
// Accumulator store: one entry per coarse cell of a plane.
// Synchronous memory with one write port and one registered read port; uses vrv_pkg.
module vrv_acc_mem #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  vrv_pkg::acc_entry_t wdata,
	input  logic                re,
	input  logic [AW-1:0]       raddr,
	output vrv_pkg::acc_entry_t rdata
);
	import vrv_pkg::*;

	acc_entry_t mem [DEPTH];
	acc_entry_t rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/vrv_div.sv */
// Bit-serial restoring divider for the rounded block mean.
// Divides a 35-bit magnitude by a count of 1 to 8 and applies the sign; uses vrv_pkg.
module vrv_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  vrv_pkg::div_req_t        req,
	output logic                     busy,
	output logic signed [31:0]       quot
);
	import vrv_pkg::*;

	logic                busy_q;
	logic [STEP_W-1:0]   step_q;
	logic [SUM_W-1:0]    dq_q;
	logic [CNT_W-1:0]    rem_q;
	logic [CNT_W-1:0]    den_q;
	logic                neg_q;
	logic [CNT_W:0]      trial;
	logic                fits;
	logic [CNT_W:0]      diff;
	logic [VALUE_W-1:0]  qmag;

	// One trial subtraction per step; the remainder stays below the divisor.
	assign trial = {rem_q, dq_q[SUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(DIV_STEPS);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath: the dividend shifts out as quotient bits shift in.
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= req.mag;
			rem_q <= '0;
			den_q <= req.den;
			neg_q <= req.neg;
		end else if (busy_q) begin
			dq_q  <= {dq_q[SUM_W-2:0], fits};
			rem_q <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

	// The quotient always fits in 32 bits; restore the sign.
	assign qmag = dq_q[VALUE_W-1:0];
	assign quot = neg_q ? $signed(VALUE_W'(0) - qmag) : $signed(qmag);
	assign busy = busy_q;

endmodule

/* hw/rtl/voxel_restrict_2to1_vote.sv */
// Top level of the 2:1 voxel restriction block: raster position tracking, sequencer,
// accumulator update, type vote and output register. Uses vrv_pkg, vrv_acc_mem, vrv_div.
//
//   Channel | Handshake             | Payload
//   --------+-----------------------+-------------------------------------------
//   input   | in_valid / in_ready   | fine_value[31:0], voxel_type[1:0]
//   output  | out_valid / out_ready | coarse_value[31:0], cell_type[1:0], last_cell
//   config  | cfg_valid / cfg_ready | cfg_index[1:0], cfg_data[8:0]
//
// A voxel that closes no coarse cell goes through accept with memory read, then write-back.
// A voxel that closes a cell also goes through divider setup and the 35-step bit-serial divider.
// Reset clears positions, sizes (to 256, clamped to the maximum) and the sequencer; the
// accumulator store needs no clearing since the first voxel of a block ignores the stored entry.
// A result waiting in the output register does not stop the next voxel unless another
// result is ready to load behind it.
module voxel_restrict_2to1_vote #(
	parameter int MAX_FINE_X = 256,
	parameter int MAX_FINE_Y = 256,
	parameter int MAX_FINE_Z = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] fine_value,
	input  logic [1:0]         voxel_type,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] coarse_value,
	output logic [1:0]         cell_type,
	output logic               last_cell,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [8:0]         cfg_data
);
	import vrv_pkg::*;

	// A size register never exceeds 511, so positions and cells follow the smaller bound.
	localparam int LIM_X = (MAX_FINE_X > 511) ? 511 : MAX_FINE_X;
	localparam int LIM_Y = (MAX_FINE_Y > 511) ? 511 : MAX_FINE_Y;
	localparam int LIM_Z = (MAX_FINE_Z > 511) ? 511 : MAX_FINE_Z;
	localparam int PXW   = $clog2(LIM_X);
	localparam int PYW   = $clog2(LIM_Y);
	localparam int PZW   = $clog2(LIM_Z);
	localparam int CELLS_X = (LIM_X + 1) / 2;
	localparam int CELLS_Y = (LIM_Y + 1) / 2;
	localparam int DEPTH   = CELLS_X * CELLS_Y;
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CFG_W-1:0] RST_X = CFG_W'((MAX_FINE_X < 256) ? MAX_FINE_X : 256);
	localparam logic [CFG_W-1:0] RST_Y = CFG_W'((MAX_FINE_Y < 256) ? MAX_FINE_Y : 256);
	localparam logic [CFG_W-1:0] RST_Z = CFG_W'((MAX_FINE_Z < 256) ? MAX_FINE_Z : 256);

	state_t             state_q;
	logic [CFG_W-1:0]   size_x_q, size_y_q, size_z_q;
	logic [PXW-1:0]     pos_x_q;
	logic [PYW-1:0]     pos_y_q;
	logic [PZW-1:0]     pos_z_q;
	logic [CFG_W-1:0]   cfg_s;
	logic [CFG_W-1:0]   clamp_x, clamp_y, clamp_z;
	logic               cfg_hit;
	logic               in_acc;
	logic [PXW:0]       px1;
	logic [PYW:0]       py1;
	logic [PZW:0]       pz1;
	logic               wrap_x, wrap_y, wrap_z;
	logic               fresh, close_cell;
	logic [AW-1:0]      addr;
	logic [AW-1:0]      addr_q;
	logic signed [VALUE_W-1:0] val_q;
	logic [1:0]         type_q;
	logic               fresh_q, close_q, last_q;
	acc_entry_t         rd_ent, base, upd, ent_q;
	logic [CNT_W-1:0]   air;
	logic [1:0]         vote;
	logic [1:0]         vote_q;
	logic               last_s2;
	div_req_t           dreq;
	logic               div_start, div_busy;
	logic signed [31:0] div_quot;
	logic               out_load;
	logic               out_valid_q;
	logic signed [31:0] coarse_value_q;
	logic [1:0]         cell_type_q;
	logic               last_cell_q;

	assign in_ready  = state_q == ST_IDLE;
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;

	// Size clamping: zero acts as one, anything above the maximum acts as the maximum.
	assign cfg_s   = (cfg_data == '0) ? CFG_W'(1) : cfg_data;
	assign clamp_x = (int'(cfg_s) > MAX_FINE_X) ? CFG_W'(MAX_FINE_X) : cfg_s;
	assign clamp_y = (int'(cfg_s) > MAX_FINE_Y) ? CFG_W'(MAX_FINE_Y) : cfg_s;
	assign clamp_z = (int'(cfg_s) > MAX_FINE_Z) ? CFG_W'(MAX_FINE_Z) : cfg_s;
	assign cfg_hit = cfg_valid && (cfg_index == CFG_SIZE_X || cfg_index == CFG_SIZE_Y ||
		cfg_index == CFG_SIZE_Z);

	// Position decode for the voxel now at the input.
	assign px1    = {1'b0, pos_x_q} + 1'b1;
	assign py1    = {1'b0, pos_y_q} + 1'b1;
	assign pz1    = {1'b0, pos_z_q} + 1'b1;
	assign wrap_x = 10'(px1) >= 10'(size_x_q);
	assign wrap_y = 10'(py1) >= 10'(size_y_q);
	assign wrap_z = 10'(pz1) >= 10'(size_z_q);
	assign fresh  = !pos_x_q[0] && !pos_y_q[0] && !pos_z_q[0];
	assign close_cell = (pos_x_q[0] || wrap_x) && (pos_y_q[0] || wrap_y) &&
		(pos_z_q[0] || wrap_z);
	assign addr = AW'(pos_x_q >> 1) + AW'(AW'(pos_y_q >> 1) * AW'(CELLS_X));

	// Size registers and raster position; a size write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= RST_X;
			size_y_q <= RST_Y;
			size_z_q <= RST_Z;
			pos_x_q  <= '0;
			pos_y_q  <= '0;
			pos_z_q  <= '0;
		end else if (cfg_hit) begin
			case (cfg_index)
				CFG_SIZE_X: size_x_q <= clamp_x;
				CFG_SIZE_Y: size_y_q <= clamp_y;
				CFG_SIZE_Z: size_z_q <= clamp_z;
				default: ;
			endcase
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
		end else if (in_acc) begin
			if (!wrap_x) begin
				pos_x_q <= PXW'(px1);
			end else begin
				pos_x_q <= '0;
				if (!wrap_y) begin
					pos_y_q <= PYW'(py1);
				end else begin
					pos_y_q <= '0;
					pos_z_q <= wrap_z ? '0 : PZW'(pz1);
				end
			end
		end
	end

	// Request capture at accept.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			val_q   <= fine_value;
			type_q  <= voxel_type;
			addr_q  <= addr;
			fresh_q <= fresh;
			close_q <= close_cell;
			last_q  <= wrap_x && wrap_y && wrap_z;
		end
	end

	// Accumulator store: read at accept, written back in the next cycle.
	vrv_acc_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (state_q == ST_RD),
		.waddr (addr_q),
		.wdata (upd),
		.re    (in_acc),
		.raddr (addr),
		.rdata (rd_ent)
	);

	// Entry update: the first voxel of a block starts from an empty entry.
	always_comb begin
		base       = fresh_q ? '0 : rd_ent;
		upd.sum    = base.sum + SUM_W'(val_q);
		upd.count  = base.count + 1'b1;
		upd.solid  = base.solid + CNT_W'(type_q == TYPE_SOLID);
		upd.anchor = base.anchor + CNT_W'(type_q == TYPE_ANCHOR);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RD) begin
			ent_q   <= upd;
			last_s2 <= last_q;
		end
	end

	// Type vote with ties going to anchor, then solid.
	assign air = ent_q.count - ent_q.anchor - ent_q.solid;
	always_comb begin
		if (ent_q.anchor >= ent_q.solid && ent_q.anchor >= air) begin
			vote = TYPE_ANCHOR;
		end else if (ent_q.solid >= air) begin
			vote = TYPE_SOLID;
		end else begin
			vote = TYPE_AIR;
		end
	end

	// Divider request: magnitude plus half the count gives round half away from zero.
	assign dreq.neg = ent_q.sum[SUM_W-1];
	assign dreq.mag = (dreq.neg ? (SUM_W'(0) - SUM_W'(ent_q.sum)) : SUM_W'(ent_q.sum)) +
		SUM_W'(ent_q.count >> 1);
	assign dreq.den = ent_q.count;
	assign div_start = state_q == ST_PREP;

	always_ff @(posedge clk) begin
		if (div_start) begin
			vote_q <= vote;
		end
	end

	vrv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.req    (dreq),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	assign out_load = (state_q == ST_DIV) && !div_busy && (!out_valid_q || out_ready);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_acc) state_q <= ST_RD;
				ST_RD:   state_q <= close_q ? ST_PREP : ST_IDLE;
				ST_PREP: state_q <= ST_DIV;
				ST_DIV:  if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			coarse_value_q <= div_quot;
			cell_type_q    <= vote_q;
			last_cell_q    <= last_s2;
		end
	end

	assign out_valid    = out_valid_q;
	assign coarse_value = coarse_value_q;
	assign cell_type    = cell_type_q;
	assign last_cell    = last_cell_q;

`ifndef SYNTHESIS
	// An accepted voxel always goes to the write-back cycle next.
	a_accept_to_rd: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_RD)
		else $error("accepted voxel did not reach write-back");

	// The divider never sees an empty entry.
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> ent_q.count != '0)
		else $error("divider started with zero count");

	// No voxel is taken while a mean is being computed.
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> !in_ready)
		else $error("input ready while divider busy");

	// A size write restarts the frame.
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> pos_x_q == '0 && pos_y_q == '0 && pos_z_q == '0)
		else $error("size write did not restart the frame");

	// The vote never produces the unused type code.
	a_vote_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> cell_type_q != 2'd3)
		else $error("invalid cell type");
`endif

endmodule

/* tb/voxel_restrict_2to1_vote_chk.sv */
// Checker for the 2:1 voxel restriction block: watches the voxel, config and coarse-cell
// channels, predicts every coarse cell and compares it field by field with what comes out.
// Depends on vrv_pkg for the accumulator entry type, type codes and register indexes.
module voxel_restrict_2to1_vote_chk #(
	parameter int MAX_FINE_X = 256,
	parameter int MAX_FINE_Y = 256,
	parameter int MAX_FINE_Z = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [31:0] fine_value,
	input  logic [1:0]         voxel_type,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] coarse_value,
	input  logic [1:0]         cell_type,
	input  logic               last_cell,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [8:0]         cfg_data,
	output int                 errors,
	output int                 cells_waiting,
	output int                 cells_checked
);
	import vrv_pkg::*;

	localparam int CELLS_X    = (MAX_FINE_X + 1) / 2;
	localparam int CELLS_Y    = (MAX_FINE_Y + 1) / 2;
	localparam int REPORT_CAP = 40;

	// One predicted coarse cell.
	typedef struct packed {
		logic signed [31:0] value;
		logic [1:0]         kind;
		logic               last;
	} coarse_cell_t;

	acc_entry_t   plane_sums [CELLS_X * CELLS_Y];
	coarse_cell_t cells_q [$];
	int           size_x, size_y, size_z;
	int           pos_x, pos_y, pos_z;
	int           err_cnt;
	int           checked_cnt;

	// Register values of zero act as one; values past the maximum act as the maximum.
	function automatic int clamp_extent(input logic [8:0] raw, input int limit);
		if (raw == 0)
			return 1;
		if (raw > limit)
			return limit;
		return raw;
	endfunction

	// A write to a size register restarts the frame; other indexes are ignored.
	task automatic apply_write(input logic [1:0] index, input logic [8:0] data);
		case (index)
			CFG_SIZE_X: size_x = clamp_extent(data, MAX_FINE_X);
			CFG_SIZE_Y: size_y = clamp_extent(data, MAX_FINE_Y);
			CFG_SIZE_Z: size_z = clamp_extent(data, MAX_FINE_Z);
			default: return;
		endcase
		pos_x = 0;
		pos_y = 0;
		pos_z = 0;
	endtask

	// Folds one fine voxel into its 2x2x2 block and queues the coarse cell it closes.
	task automatic fold_voxel(input logic signed [31:0] v, input logic [1:0] t);
		int           slot;
		int           n_all, n_anchor, n_solid, n_air;
		bit           fresh, close_x, close_y, close_z, grid_end;
		longint       total, mag, q;
		acc_entry_t   e;
		coarse_cell_t c;

		slot     = (pos_x >> 1) + (pos_y >> 1) * CELLS_X;
		fresh    = ((pos_x | pos_y | pos_z) & 1) == 0;
		close_x  = (pos_x % 2) != 0 || pos_x + 1 >= size_x;
		close_y  = (pos_y % 2) != 0 || pos_y + 1 >= size_y;
		close_z  = (pos_z % 2) != 0 || pos_z + 1 >= size_z;
		grid_end = pos_x + 1 >= size_x && pos_y + 1 >= size_y && pos_z + 1 >= size_z;

		// The first voxel of a block starts a new sum instead of adding to the old one.
		e = fresh ? '0 : plane_sums[slot];
		e.sum   = e.sum + v;
		e.count = e.count + 1;
		if (t == TYPE_ANCHOR)
			e.anchor = e.anchor + 1;
		else if (t == TYPE_SOLID)
			e.solid = e.solid + 1;
		plane_sums[slot] = e;

		if (close_x && close_y && close_z) begin
			n_all    = e.count;
			n_anchor = e.anchor;
			n_solid  = e.solid;
			n_air    = n_all - n_anchor - n_solid;
			// Mean rounded to nearest, halves away from zero.
			total = e.sum;
			mag   = (total < 0) ? -total : total;
			q     = (mag + n_all / 2) / n_all;
			c.value = (total < 0) ? -q : q;
			// Majority vote with ties going to anchor, then solid.
			if (n_anchor >= n_solid && n_anchor >= n_air)
				c.kind = TYPE_ANCHOR;
			else if (n_solid >= n_air)
				c.kind = TYPE_SOLID;
			else
				c.kind = TYPE_AIR;
			c.last = grid_end;
			cells_q.push_back(c);
		end

		// Raster advance, wrapping to a new frame after the last voxel.
		pos_x++;
		if (pos_x >= size_x) begin
			pos_x = 0;
			pos_y++;
			if (pos_y >= size_y) begin
				pos_y = 0;
				pos_z++;
				if (pos_z >= size_z)
					pos_z = 0;
			end
		end
	endtask

	task automatic note_mismatch(input string field, input longint want_v, input longint got_v);
		err_cnt++;
		if (err_cnt <= REPORT_CAP)
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want_v, got_v);
	endtask

	// Track every request on the three channels; results are checked in order.
	always @(posedge clk or negedge arst_n) begin
		coarse_cell_t want;
		if (!arst_n) begin
			size_x = clamp_extent(9'd256, MAX_FINE_X);
			size_y = clamp_extent(9'd256, MAX_FINE_Y);
			size_z = clamp_extent(9'd256, MAX_FINE_Z);
			pos_x = 0;
			pos_y = 0;
			pos_z = 0;
			cells_q.delete();
			err_cnt = 0;
			checked_cnt = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				apply_write(cfg_index, cfg_data);
			if (in_valid && in_ready)
				fold_voxel(fine_value, voxel_type);
			if (out_valid && out_ready) begin
				if (cells_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= REPORT_CAP)
						$display("%0t: unexpected cell: expected none, got %0d/%0d/%0d",
							$time, coarse_value, cell_type, last_cell);
				end else begin
					want = cells_q.pop_front();
					checked_cnt++;
					if (coarse_value !== want.value)
						note_mismatch("coarse_value", want.value, coarse_value);
					if (cell_type !== want.kind)
						note_mismatch("cell_type", want.kind, cell_type);
					if (last_cell !== want.last)
						note_mismatch("last_cell", want.last, last_cell);
				end
			end
		end
		errors        <= err_cnt;
		cells_waiting <= cells_q.size();
		cells_checked <= checked_cnt;
	end

endmodule

/* tb/voxel_restrict_2to1_vote_tb.sv */
// Top of the testbench for the 2:1 voxel restriction block: clock, reset, voxel and
// register stimulus, receiver stalls and the verdict. Uses vrv_pkg and the cell checker.
module voxel_restrict_2to1_vote_tb;
	import vrv_pkg::*;

	localparam int         MAX_EXTENT   = 256;
	localparam int         DRAIN_CYCLES = 48;
	localparam int         CYCLE_LIMIT  = 1000000;
	localparam int         PHASE_ITEMS  = 660;
	localparam logic [1:0] TYPE_OTHER   = 2'd3;
	localparam logic [1:0] CFG_UNUSED   = 2'd3;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               in_valid     = 1'b0;
	logic               in_ready;
	logic signed [31:0] fine_value   = '0;
	logic [1:0]         voxel_type   = TYPE_AIR;
	logic               out_valid;
	logic               out_ready    = 1'b0;
	logic signed [31:0] coarse_value;
	logic [1:0]         cell_type;
	logic               last_cell;
	logic               cfg_valid    = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index    = CFG_SIZE_X;
	logic [8:0]         cfg_data     = '0;

	int errors;
	int cells_waiting;
	int cells_checked;
	int items_sent   = 0;
	int regs_written = 0;
	int send_idle    = 0;
	int recv_idle    = 0;
	int cycle_count  = 0;

	voxel_restrict_2to1_vote dut (.*);

	voxel_restrict_2to1_vote_chk chk (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Hard stop for a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// The receiver stalls at random, at the rate of the current phase.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	// Mostly raw random words, with extremes and small values that exercise rounding.
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2, 3: return 32'($urandom_range(0, 16) - 8);
			default: return $urandom();
		endcase
	endfunction

	// At least half of the voxels follow the frame's favored type so every vote outcome shows up.
	function automatic logic [1:0] pick_type(input logic [1:0] bias);
		return $urandom_range(0, 1) ? bias : 2'($urandom_range(0, 3));
	endfunction

	// Offers one voxel request and returns at the edge that takes it; valid stays up.
	task automatic send_voxel(input logic signed [31:0] v, input logic [1:0] t);
		// Release the config channel once voxels flow again.
		cfg_valid <= 1'b0;
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		fine_value <= v;
		voxel_type <= t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [8:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		regs_written++;
	endtask

	// Stops sending, waits for every predicted cell, then lets the divider finish.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (cells_waiting != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One grid setting and a run of voxels: whole frames, back-to-back frames or a cut-off one.
	task automatic random_frame();
		logic [8:0] raw [3];
		int         extent [3];
		int         volume;
		int         count;
		int         wide;
		logic [1:0] bias;

		settle();
		wide = $urandom_range(0, 29);
		for (int a = 0; a < 3; a++) begin
			if (a == wide) begin
				case ($urandom_range(0, 4))
					0: raw[a] = 9'd511;
					1: raw[a] = 9'd256;
					2: raw[a] = 9'd255;
					3: raw[a] = 9'd257;
					default: raw[a] = 9'($urandom_range(8, 511));
				endcase
			end else if (wide < 3) begin
				raw[a] = 9'($urandom_range(0, 1));
			end else begin
				raw[a] = 9'($urandom_range(0, 7));
			end
			extent[a] = (raw[a] == 0) ? 1 : ((raw[a] > MAX_EXTENT) ? MAX_EXTENT : raw[a]);
		end
		write_reg(CFG_SIZE_X, raw[0]);
		write_reg(CFG_SIZE_Y, raw[1]);
		write_reg(CFG_SIZE_Z, raw[2]);
		if ($urandom_range(0, 7) == 0)
			write_reg(CFG_UNUSED, 9'($urandom()));

		volume = extent[0] * extent[1] * extent[2];
		case ($urandom_range(0, 19))
			0, 1, 2: count = $urandom_range(1, volume);
			3, 4, 5: count = (volume <= 64) ? 2 * volume : volume;
			default: count = volume;
		endcase
		bias = 2'($urandom_range(0, 3));
		repeat (count) send_voxel(pick_value(), pick_type(bias));
	endtask

	initial begin
		logic [1:0] vote_mix [8];
		int         target;

		vote_mix  = '{TYPE_ANCHOR, TYPE_ANCHOR, TYPE_SOLID, TYPE_SOLID,
			TYPE_AIR, TYPE_AIR, TYPE_OTHER, TYPE_OTHER};
		send_idle = 33;
		recv_idle = 46;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset sizes: a lone voxel moves the position without closing any cell.
		send_voxel(32'sh7FFF_FFFF, TYPE_ANCHOR);
		settle();

		// Size zero acts as one, so every voxel is a whole grid on its own.
		write_reg(CFG_SIZE_X, 9'd0);
		write_reg(CFG_SIZE_Y, 9'd0);
		write_reg(CFG_SIZE_Z, 9'd0);
		send_voxel(32'sh8000_0000, TYPE_OTHER);
		send_voxel(-32'sd1, TYPE_SOLID);
		settle();

		// Pairs along x: halves round away from zero and vote ties go to the heavier type.
		write_reg(CFG_SIZE_X, 9'd2);
		send_voxel(-32'sd1, TYPE_ANCHOR);
		send_voxel(32'sd0, TYPE_SOLID);
		send_voxel(32'sd1, TYPE_SOLID);
		send_voxel(32'sd0, TYPE_AIR);
		settle();

		// One full block of the largest value, with air ahead in the vote.
		write_reg(CFG_SIZE_Y, 9'd2);
		write_reg(CFG_SIZE_Z, 9'd2);
		foreach (vote_mix[i])
			send_voxel(32'sh7FFF_FFFF, vote_mix[i]);

		// A write to an unused index in mid-block must not restart the frame.
		repeat (4) send_voxel(32'sh8000_0000, TYPE_ANCHOR);
		settle();
		write_reg(CFG_UNUSED, 9'h1FF);
		send_voxel(32'sh8000_0000, TYPE_AIR);
		send_voxel(32'sh8000_0000, TYPE_OTHER);
		send_voxel(32'sh8000_0000, TYPE_SOLID);
		send_voxel(32'sh8000_0000, TYPE_ANCHOR);

		// Leave a block half done; the next size write has to restart from scratch.
		repeat (3) send_voxel(pick_value(), pick_type(TYPE_SOLID));

		// Random grids under three idle mixes, the last one with no idling at all.
		for (int phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 33 : ((phase == 1) ? 46 : 0);
			recv_idle = (phase == 0) ? 46 : ((phase == 1) ? 33 : 0);
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target)
				random_frame();
		end
		settle();

		$display("Run covered %0d voxels, %0d coarse cells and %0d register writes.",
			items_sent, cells_checked, regs_written);
		$display("Grids went from single voxels to 256-voxel axes; idle mixes 33/46, 46/33, none.");
		if (errors == 0 && cells_waiting == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
